@@ rtl/core/timeout_slot_table_assert.svh @@
// Assertion macros shared by the timeout slot table RTL.
`ifndef TIMEOUT_SLOT_TABLE_ASSERT_SVH
`define TIMEOUT_SLOT_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TST_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tst_pkg.sv @@
`default_nettype none
package tst_pkg;

    localparam int SLOT_COUNT = 20;
    localparam int CNT_W      = 16;
    localparam int ID_W       = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ID_W-1:0]  id_t;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_STARTED   = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_EXPIRED   = 3'd4,
        KIND_QUIET     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic  used;
        id_t   id;
        cnt_t  wait_len;
        cnt_t  start;
        logic  notify;
    } slot_t;

    typedef struct packed {
        logic  set;
        logic  clr;
        idx_t  idx;
        id_t   id;
        cnt_t  wait_len;
        cnt_t  start;
        logic  notify;
    } slot_wr_t;

    typedef struct packed {
        id_t   id;
        cnt_t  wait_len;
        cnt_t  now;
    } item_t;

    typedef struct packed {
        logic  free;
        logic  match;
        logic  expired;
    } eval_t;

endpackage
`default_nettype wire

@@ rtl/core/tst_slot_store.sv @@
`default_nettype none
module tst_slot_store
    import tst_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire idx_t     rd_idx,
    output slot_t         rd_entry,
    input  wire slot_wr_t wr
);

    logic [SLOT_COUNT-1:0] used_reg;
    id_t                   id_reg     [SLOT_COUNT];
    cnt_t                  wait_reg   [SLOT_COUNT];
    cnt_t                  start_reg  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] notify_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (wr.set) begin
            used_reg[wr.idx] <= 1'b1;
        end else if (wr.clr) begin
            used_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.set) begin
            id_reg[wr.idx]     <= wr.id;
            wait_reg[wr.idx]   <= wr.wait_len;
            start_reg[wr.idx]  <= wr.start;
            notify_reg[wr.idx] <= wr.notify;
        end
    end

    always_comb begin
        rd_entry.used     = used_reg[rd_idx];
        rd_entry.id       = id_reg[rd_idx];
        rd_entry.wait_len = wait_reg[rd_idx];
        rd_entry.start    = start_reg[rd_idx];
        rd_entry.notify   = notify_reg[rd_idx];
    end

endmodule
`default_nettype wire

@@ rtl/core/tst_slot_eval.sv @@
`default_nettype none
module tst_slot_eval
    import tst_pkg::*;
(
    input  wire slot_t entry,
    input  wire item_t item,
    output eval_t      ev
);

    logic [CNT_W:0] due;

    always_comb begin
        due        = {1'b0, entry.start} + {1'b0, entry.wait_len};
        ev.free    = !entry.used;
        ev.match   = entry.used && (entry.id == item.id) && (entry.wait_len == item.wait_len);
        if (due[CNT_W]) begin
            ev.expired = entry.used && (item.now < entry.start) && (item.now >= due[CNT_W-1:0]);
        end else begin
            ev.expired = entry.used && (item.now >= due[CNT_W-1:0]);
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/timeout_slot_table.sv @@
// Timeout slot table over a free-running wrapping counter.
// Input words arrive on the s_ channel: s_tuser carries the mode (start,
// cancel or tick) and s_tdata the timer id, wait length, notify flag and the
// current counter value. Results leave on the m_ channel: m_tuser is the
// result kind, m_tdata the expired id, and m_tlast marks the final result
// of one input word. Start and cancel give one result; a tick gives one
// result per expired slot with notify set, or a single quiet result.
// The slots are scanned one per cycle through a single compare unit when no
// stall holds the scan. A word with the unused mode is accepted and gives no
// result. s_tready is high only in the idle state, so it is low while a word
// is scanned and while a tick's final result waits to be loaded. A stalled
// receiver holds the output register and pauses the scan only when a new
// result must be loaded.
// A synchronous reset frees all slots and drops any pending result.
`default_nettype none
module timeout_slot_table
    import tst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: timer_id[15:0], wait_ticks[31:16], notify[32],
    // now_count[48:33], zero fill.
    input  wire logic [55:0] s_tdata,
    // Fields from bit 0: mode[1:0].
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: expired_id[15:0].
    output logic [15:0]      m_tdata,
    // Fields from bit 0: kind[2:0].
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    state_t   state_reg, state_next;
    mode_t    mode_reg;
    item_t    item_reg;
    logic     notify_reg;
    idx_t     idx_reg, idx_next;
    logic     held_valid_reg, held_valid_next;
    id_t      held_id_reg, held_id_next;
    logic     out_valid_reg;
    kind_t    out_kind_reg;
    id_t      out_id_reg;
    logic     out_last_reg;

    slot_t    entry;
    eval_t    ev;
    slot_wr_t wr;

    logic     accept;
    logic     at_end;
    logic     out_free;
    logic     tick_hit;
    logic     found;
    logic     need_push;
    logic     step_ok;
    logic     push;
    kind_t    push_kind;
    id_t      push_id;
    logic     push_last;

    tst_slot_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (idx_reg),
        .rd_entry (entry),
        .wr       (wr)
    );

    tst_slot_eval u_eval (
        .entry (entry),
        .item  (item_reg),
        .ev    (ev)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_id_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        at_end   = (idx_reg == LAST_IDX);
        out_free = !out_valid_reg || m_tready;
        tick_hit = ev.expired;
        unique case (mode_reg)
            MODE_START:  found = ev.free;
            MODE_CANCEL: found = ev.match;
            default:     found = tick_hit;
        endcase
        if (state_reg == ST_SCAN) begin
            if (mode_reg == MODE_TICK) begin
                need_push = tick_hit && entry.notify && held_valid_reg;
            end else begin
                need_push = found || at_end;
            end
        end else begin
            need_push = 1'b0;
        end
        step_ok = !need_push || out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (mode_t'(s_tuser) != MODE_NONE)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step_ok) begin
                    if (mode_reg == MODE_TICK) begin
                        if (at_end) begin
                            state_next = ST_FLUSH;
                        end
                    end else if (found || at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next        = idx_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        push            = 1'b0;
        push_kind       = KIND_QUIET;
        push_id         = '0;
        push_last       = 1'b1;
        wr.set          = 1'b0;
        wr.clr          = 1'b0;
        wr.idx          = idx_reg;
        wr.id           = item_reg.id;
        wr.wait_len     = item_reg.wait_len;
        wr.start        = item_reg.now;
        wr.notify       = notify_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next        = '0;
                held_valid_next = 1'b0;
            end
            ST_SCAN: begin
                if (step_ok) begin
                    idx_next = idx_reg + idx_t'(1);
                    unique case (mode_reg)
                        MODE_START: begin
                            if (found || at_end) begin
                                push      = 1'b1;
                                push_kind = found ? KIND_STARTED : KIND_FULL;
                                wr.set    = found;
                            end
                        end
                        MODE_CANCEL: begin
                            if (found || at_end) begin
                                push      = 1'b1;
                                push_kind = found ? KIND_CANCELLED : KIND_NOT_FOUND;
                                wr.clr    = found;
                            end
                        end
                        default: begin
                            if (tick_hit) begin
                                wr.clr = 1'b1;
                                if (entry.notify) begin
                                    push            = held_valid_reg;
                                    push_kind       = KIND_EXPIRED;
                                    push_id         = held_id_reg;
                                    push_last       = 1'b0;
                                    held_valid_next = 1'b1;
                                    held_id_next    = entry.id;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push            = 1'b1;
                    push_kind       = held_valid_reg ? KIND_EXPIRED : KIND_QUIET;
                    push_id         = held_valid_reg ? held_id_reg : '0;
                    held_valid_next = 1'b0;
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        held_id_reg <= held_id_next;
        if (accept) begin
            mode_reg          <= mode_t'(s_tuser);
            item_reg.id       <= s_tdata[15:0];
            item_reg.wait_len <= s_tdata[31:16];
            notify_reg        <= s_tdata[32];
            item_reg.now      <= s_tdata[48:33];
        end
        if (push) begin
            out_kind_reg <= push_kind;
            out_id_reg   <= push_id;
            out_last_reg <= push_last;
        end
    end

`include "timeout_slot_table_assert.svh"

    `TST_ASSERT_SAME(a_held_only_in_tick, aclk, aresetn, held_valid_reg, (mode_reg == MODE_TICK) && (state_reg == ST_SCAN || state_reg == ST_FLUSH), "Pending expiry outside a tick scan.")
    `TST_ASSERT_SAME(a_idx_in_range, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= LAST_IDX, "Scan index beyond the last slot.")
    `TST_ASSERT_NEXT(a_accept_starts_scan, aclk, aresetn, accept && (s_tuser != MODE_NONE), state_reg == ST_SCAN && idx_reg == '0, "Accepted word did not start a scan at slot zero.")
    `TST_ASSERT_SAME(a_no_double_write, aclk, aresetn, wr.set, !wr.clr && push && out_free, "Slot set without its result being loaded.")

endmodule
`default_nettype wire
